[rtl/cce_pkg.sv]
// CRC engine package: variant codes, result struct and the byte fold functions.
// No dependencies; used by configurable_crc_engine.
package cce_pkg;

  // Variant register codes (codes above CRC16_MSB behave as CRC16_MSB)
  localparam logic [2:0] VAR_CRC4      = 3'd0;
  localparam logic [2:0] VAR_CRC7      = 3'd1;
  localparam logic [2:0] VAR_CRC8      = 3'd2;
  localparam logic [2:0] VAR_CRC8_REFL = 3'd3;
  localparam logic [2:0] VAR_CRC16_LSB = 3'd4;
  localparam logic [2:0] VAR_CRC16_MSB = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] REG_VARIANT = 2'd0;
  localparam logic [1:0] REG_POLY    = 2'd1;
  localparam logic [1:0] REG_INIT    = 2'd2;

  localparam int unsigned CRC_W = 16;

  typedef struct packed {
    logic [CRC_W-1:0] remainder;
    logic [CRC_W-1:0] crc;
  } fold_res_t;

  function automatic logic [7:0] rev8(input logic [7:0] x);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = x[7-i];
    end
    return r;
  endfunction

  // Eight MSB-first shift steps on an 8-bit remainder
  function automatic logic [7:0] fold_msb8(input logic [7:0] r, input logic [7:0] d,
                                           input logic [7:0] p);
    logic [7:0] x;
    x = r ^ d;
    for (int i = 0; i < 8; i++) begin
      x = x[7] ? ({x[6:0], 1'b0} ^ p) : {x[6:0], 1'b0};
    end
    return x;
  endfunction

  // Eight LSB-first shift steps on an 8-bit remainder
  function automatic logic [7:0] fold_lsb8(input logic [7:0] r, input logic [7:0] d,
                                           input logic [7:0] p);
    logic [7:0] x;
    x = r ^ d;
    for (int i = 0; i < 8; i++) begin
      x = x[0] ? ({1'b0, x[7:1]} ^ p) : {1'b0, x[7:1]};
    end
    return x;
  endfunction

  function automatic logic [15:0] fold_msb16(input logic [15:0] r, input logic [7:0] d,
                                             input logic [15:0] p);
    logic [15:0] x;
    x = r ^ {d, 8'h00};
    for (int i = 0; i < 8; i++) begin
      x = x[15] ? ({x[14:0], 1'b0} ^ p) : {x[14:0], 1'b0};
    end
    return x;
  endfunction

  function automatic logic [15:0] fold_lsb16(input logic [15:0] r, input logic [7:0] d,
                                             input logic [15:0] p);
    logic [15:0] x;
    x = r ^ {8'h00, d};
    for (int i = 0; i < 8; i++) begin
      x = x[0] ? ({1'b0, x[15:1]} ^ p) : {1'b0, x[15:1]};
    end
    return x;
  endfunction

  // One byte under the selected variant: new remainder and right-aligned CRC
  function automatic fold_res_t crc_fold(input logic [2:0] variant,
                                         input logic [15:0] poly,
                                         input logic [15:0] init,
                                         input logic [15:0] rem,
                                         input logic [7:0] d,
                                         input logic first);
    fold_res_t  o;
    logic [7:0] r8;
    logic [7:0] n8;
    logic [15:0] r16;
    logic [15:0] n16;
    r8  = 8'h00;
    n8  = 8'h00;
    r16 = 16'h0000;
    n16 = 16'h0000;
    case (variant)
      VAR_CRC4: begin
        r8 = first ? {init[3:0], 4'h0} : rem[7:0];
        n8 = fold_msb8(r8, d, {poly[3:0], 4'h0});
        o.remainder = {8'h00, n8};
        o.crc       = {12'h000, n8[7:4]};
      end
      VAR_CRC7: begin
        r8 = first ? {init[6:0], 1'b0} : rem[7:0];
        n8 = fold_msb8(r8, d, {poly[6:0], 1'b0});
        o.remainder = {8'h00, n8};
        o.crc       = {9'h000, n8[7:1]};
      end
      VAR_CRC8: begin
        r8 = first ? init[7:0] : rem[7:0];
        n8 = fold_msb8(r8, d, poly[7:0]);
        o.remainder = {8'h00, n8};
        o.crc       = {8'h00, n8};
      end
      VAR_CRC8_REFL: begin
        r8 = first ? rev8(init[7:0]) : rem[7:0];
        n8 = fold_lsb8(r8, d, rev8(poly[7:0]));
        o.remainder = {8'h00, n8};
        o.crc       = {8'h00, n8};
      end
      VAR_CRC16_LSB: begin
        r16 = first ? init : rem;
        n16 = fold_lsb16(r16, d, poly);
        o.remainder = n16;
        o.crc       = n16;
      end
      default: begin
        // CRC16 MSB-first, also the unused codes
        r16 = first ? init : rem;
        n16 = fold_msb16(r16, d, poly);
        o.remainder = n16;
        o.crc       = n16;
      end
    endcase
    return o;
  endfunction

endpackage

[rtl/configurable_crc_engine.sv]
// Channel   Dir  Signals                                  Transaction
// input     in   in_valid, in_stall, data_byte, first_byte one message byte
// output    out  out_valid, out_stall, crc_value          CRC of message so far
// config    in   write_en, reg_index, write_data          one register write
//
// One byte per cycle sustained while in_stall is low; a byte passes input register, fold, crc_value.
// The rate is set by the remainder loop: remainder -> fold -> remainder, fed by the input register.
// Synchronous active-high reset: variant = CRC16 LSB-first, poly/init/remainder = 0.
// A two-entry output buffer absorbs stalls; in_stall comes only from registers.
//
// Top level of the configurable CRC engine; depends on cce_pkg.
module configurable_crc_engine
  import cce_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] crc_value,
  input  logic        write_en,
  input  logic [1:0]  reg_index,
  input  logic [15:0] write_data
);

  logic [2:0]  variant;
  logic [15:0] poly_value;
  logic [15:0] init_value;
  logic [15:0] remainder;

  logic        in_q_valid;
  logic [7:0]  in_q_data;
  logic        in_q_first;

  logic        skid_valid;
  logic [15:0] skid_crc;

  logic        in_take;
  logic        push;
  logic        pop;
  fold_res_t   fold;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      variant    <= VAR_CRC16_LSB;
      poly_value <= '0;
      init_value <= '0;
    end else if (write_en) begin
      case (reg_index)
        REG_VARIANT: variant    <= write_data[2:0];
        REG_POLY:    poly_value <= write_data;
        REG_INIT:    init_value <= write_data;
        default:     ;
      endcase
    end
  end

  // Handshake
  assign in_stall = in_q_valid & skid_valid;
  assign in_take  = in_valid & ~in_stall;
  assign push     = in_q_valid & ~skid_valid;
  assign pop      = out_valid & ~out_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_take) begin
      in_q_valid <= 1'b1;
    end else if (push) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_q_data  <= data_byte;
      in_q_first <= first_byte;
    end
  end

  // Byte fold
  assign fold = crc_fold(variant, poly_value, init_value, remainder, in_q_data, in_q_first);

  always_ff @(posedge clk) begin
    if (rst) begin
      remainder <= '0;
    end else if (push) begin
      remainder <= fold.remainder;
    end
  end

  // Output register plus skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (pop) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end
      end else if (!out_valid || pop) begin
        out_valid <= push;
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        crc_value <= skid_crc;
      end
    end else if (!out_valid || pop) begin
      if (push) begin
        crc_value <= fold.crc;
      end
    end else if (push) begin
      skid_crc <= fold.crc;
    end
  end

`ifndef ASSERT_OFF
  // Skid entry is only used behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid without output valid");

  // A folded byte always lands in the output buffer
  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    push |=> out_valid)
    else $error("pushed result not visible on output");

  // Eight-bit variants keep the upper remainder byte clear
  a_narrow_rem: assert property (@(posedge clk) disable iff (rst)
    (push && (variant == VAR_CRC4 || variant == VAR_CRC7 || variant == VAR_CRC8 ||
              variant == VAR_CRC8_REFL)) |=> (remainder[15:8] == 8'h00))
    else $error("narrow variant left upper remainder bits set");
`endif

endmodule
